FILE: rtl/bit_aligned_row_blit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the row blitter checker.
// ----------------------------------------------------------------------------
`ifndef BIT_ALIGNED_ROW_BLIT_CORE_MACROS_SVH
`define BIT_ALIGNED_ROW_BLIT_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BARB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BARB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BARB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/barb_pkg.sv
// ----------------------------------------------------------------------------
// barb_pkg
// Shared constants and helpers for the bit-aligned row blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package barb_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF = 640;

    localparam int unsigned X_W    = 10;
    localparam int unsigned ROW_W  = 9;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned SPAN_MAX = 127;

    // Configuration register indexes.
    typedef enum logic {
        CFG_START_X     = 1'b0,
        CFG_PIXEL_WIDTH = 1'b1
    } t_cfg_index;

    localparam logic [7:0] MASK_FULL = 8'hff;

    // Bits from pixel column idx to the right edge of a byte.
    function automatic logic [7:0] edge_mask(input logic [2:0] idx);
        return MASK_FULL >> idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bit_aligned_row_blit_core.sv
// ----------------------------------------------------------------------------
// bit_aligned_row_blit_core
// Places one row of a 1-bit-per-pixel plane into a byte-organised frame
// buffer at any bit position, producing masked byte writes.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write start_x (index 0) and pixel_width (index 1) through
//   i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
//   Input channel (i_in_valid / o_in_ready) carries one source byte and its
//   screen row per item. Output channel (o_out_valid / i_out_ready) carries
//   one frame buffer write per item: address, bit mask, data and row_end.
//   An accepted item is registered straight into the output register, which
//   drives the output channel. Throughput is one item per cycle while the
//   receiver takes each write, set by the single output register; o_in_ready
//   stays high while that register is empty or being emptied in the same cycle.
//   With pixel_width zero, items are accepted and produce no write.
//   A stalled receiver holds the write in the output register and stops
//   further items until it is taken.
//   Reset clears the configuration, the byte position, the previous source
//   byte and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_aligned_row_blit_core #(
    parameter int unsigned SCREEN_WIDTH = barb_pkg::SCREEN_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire barb_pkg::t_cfg_index          i_cfg_index,
    input  wire logic [barb_pkg::X_W-1:0]      i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_src_byte,
    input  wire logic [barb_pkg::ROW_W-1:0]    i_row,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [barb_pkg::ADDR_W-1:0]        o_byte_address,
    output logic [7:0]                         o_bit_mask,
    output logic [7:0]                         o_write_data,
    output logic                               o_row_end
);
    import barb_pkg::*;

    localparam logic [ADDR_W-1:0] BYTES_PER_ROW = ADDR_W'(SCREEN_WIDTH / 8);

    logic [X_W-1:0]    r_start_x;
    logic [X_W-1:0]    r_pixel_width;
    logic [POS_W-1:0]  r_byte_position;
    logic [7:0]        r_prev_src;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_byte_address;
    logic [7:0]        r_bit_mask;
    logic [7:0]        r_write_data;
    logic              r_row_end;

    logic              in_accept;
    logic              emit;
    logic [2:0]        rshift;
    logic [2:0]        lshift;
    logic [X_W:0]      end_x;
    logic [7:0]        span_full;
    logic [POS_W-1:0]  span;
    logic              last;
    logic [7:0]        lmask;
    logic [7:0]        rmask;
    logic [7:0]        n_bit_mask;
    logic [7:0]        shifted_src;
    logic [7:0]        n_write_data;
    logic [ADDR_W-1:0] n_byte_address;
    logic [POS_W-1:0]  n_byte_position;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign emit       = in_accept && (r_pixel_width != '0);

    always_comb begin
        rshift    = r_start_x[2:0];
        lshift    = 3'(4'd8 - {1'b0, rshift});
        end_x     = {1'b0, r_start_x} + {1'b0, r_pixel_width};
        span_full = end_x[X_W:3] - {1'b0, r_start_x[X_W-1:3]};
        span      = (span_full > 8'(SPAN_MAX)) ? POS_W'(SPAN_MAX) : span_full[POS_W-1:0];
        last      = r_byte_position >= span;
        lmask     = edge_mask(rshift);
        rmask     = ~edge_mask(end_x[2:0]);

        if (span == '0) begin
            n_bit_mask = lmask & rmask;
        end else if (r_byte_position == '0) begin
            n_bit_mask = lmask;
        end else if (last) begin
            n_bit_mask = rmask;
        end else begin
            n_bit_mask = MASK_FULL;
        end

        // The first write of a row has no earlier byte to borrow bits from.
        shifted_src = i_src_byte >> rshift;
        if (r_byte_position == '0 || lshift == 3'd0) begin
            n_write_data = shifted_src;
        end else begin
            n_write_data = (r_prev_src << lshift) | shifted_src;
        end

        n_byte_address = ADDR_W'(r_start_x[X_W-1:3]) + ADDR_W'(i_row) * BYTES_PER_ROW
                       + ADDR_W'(r_byte_position);
        n_byte_position = last ? '0 : r_byte_position + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x       <= '0;
            r_pixel_width   <= '0;
            r_byte_position <= '0;
            r_prev_src      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_X:     r_start_x     <= i_cfg_data;
                    CFG_PIXEL_WIDTH: r_pixel_width <= i_cfg_data;
                    default: ;
                endcase
            end
            if (emit) begin
                r_byte_position <= n_byte_position;
                r_prev_src      <= i_src_byte;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte_address <= n_byte_address;
            r_bit_mask     <= n_bit_mask;
            r_write_data   <= n_write_data;
            r_row_end      <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_address = r_byte_address;
    assign o_bit_mask     = r_bit_mask;
    assign o_write_data   = r_write_data;
    assign o_row_end      = r_row_end;

endmodule

`default_nettype wire

FILE: rtl/barb_checker.sv
// ----------------------------------------------------------------------------
// barb_checker
// Port-level assertions for the bit-aligned row blitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_aligned_row_blit_core_macros.svh"

module barb_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [barb_pkg::ADDR_W-1:0] o_byte_address,
    input wire logic [7:0]                 o_bit_mask,
    input wire logic [7:0]                 o_write_data,
    input wire logic                       o_row_end
);
    import barb_pkg::*;

    `BARB_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    `BARB_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output item dropped while stalled")

    `BARB_ASSERT_NEXT(a_payload_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_byte_address) && $stable(o_bit_mask) && $stable(o_write_data) && $stable(o_row_end), "stalled output item changed")

    // A full, stalled output register must hold off new items.
    `BARB_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "item accepted over a stalled result")

    // Only the write that closes a row may carry an empty mask.
    `BARB_ASSERT_NOW(a_mask_nonzero, i_clk, i_rst_n, o_out_valid && !o_row_end, o_bit_mask != 8'h00, "empty mask before row end")

endmodule

bind bit_aligned_row_blit_core barb_checker u_barb_checker (.*);

`default_nettype wire
